// ===== hdl/ntc_lkp_pkg.sv =====
`timescale 1ns / 1ps

package ntc_lkp_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_VOLTAGE = 2'd1;
    localparam logic [1:0] REQ_RES     = 2'd2;

    // Configuration register indexes
    localparam logic REG_LOAD    = 1'b0;
    localparam logic REG_ENTRIES = 1'b1;

    // Field widths
    localparam int IDX_W  = 6;
    localparam int RES_W  = 32;
    localparam int TEMP_W = 16;
    localparam int MV_W   = 16;
    localparam int ENT_W  = 7;
    localparam int PROD_W = RES_W + MV_W;

    // Input tdata layout, lowest bit first
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_ERES_LSB  = IN_IDX_LSB + IDX_W;
    localparam int IN_ETEMP_LSB = IN_ERES_LSB + RES_W;
    localparam int IN_SRC_LSB   = IN_ETEMP_LSB + TEMP_W;
    localparam int IN_NTC_LSB   = IN_SRC_LSB + MV_W;
    localparam int IN_MRES_LSB  = IN_NTC_LSB + MV_W;
    localparam int IN_TDATA_W   = 120;

    // Output tdata layout, lowest bit first
    localparam int OUT_TEMP_LSB = 0;
    localparam int OUT_RES_LSB  = TEMP_W;
    localparam int OUT_TDATA_W  = 48;

    // Serial arithmetic step counts
    localparam int MUL_STEPS = MV_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = 6;

    localparam logic [RES_W-1:0] RES_MAX = '1;

endpackage

// ===== hdl/ntc_resistance_temperature_lookup.sv =====
`timescale 1ns / 1ps
// Flow: a table write lands at its accept edge; a resistance item runs the
// bisection search, reads both bracket entries and keeps the higher temperature;
// a voltage item with ntc below source first runs the serial multiply and divide.
// Throughput: one item in flight; writes every cycle while idle; a resistance
// or voltage item blocks input until handed over; a stalled result holds input.
// Reset: load resistor 10000, 64 entries in use; table contents undefined.
module ntc_resistance_temperature_lookup
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // entry_index, entry_resistance, entry_temperature, source_mv, ntc_mv,
    // measured_resistance, zero pad
    input  logic [ntc_lkp_pkg::IN_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [1:0]                           s_tuser,
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // temperature, resistance_used
    output logic [ntc_lkp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // range_error
    output logic [0:0]                           m_tuser,
    // Configuration
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [ntc_lkp_pkg::RES_W-1:0]        cfg_wdata
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = ((NW > ntc_lkp_pkg::ENT_W) ? NW : ntc_lkp_pkg::ENT_W) + 1;
    localparam int EW = ((NW > ntc_lkp_pkg::IDX_W) ? NW : ntc_lkp_pkg::IDX_W) + 1;
    localparam int RW = ntc_lkp_pkg::RES_W;
    localparam int TW = ntc_lkp_pkg::TEMP_W;
    localparam int MW = ntc_lkp_pkg::MV_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ARITH = 4'd1;
    localparam logic [3:0] ST_SINIT = 4'd2;
    localparam logic [3:0] ST_SREAD = 4'd3;
    localparam logic [3:0] ST_SCMP  = 4'd4;
    localparam logic [3:0] ST_FLO   = 4'd5;
    localparam logic [3:0] ST_FHI   = 4'd6;
    localparam logic [3:0] ST_FMAX  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    // Input fields
    logic [1:0]                      req_type;
    logic [ntc_lkp_pkg::IDX_W-1:0]   entry_index;
    logic [RW-1:0]                   entry_resistance;
    logic [TW-1:0]                   entry_temperature;
    logic [MW-1:0]                   source_mv;
    logic [MW-1:0]                   ntc_mv;
    logic [RW-1:0]                   measured_resistance;

    // Configuration
    logic [RW-1:0]                   load_resistor_reg;
    logic [ntc_lkp_pkg::ENT_W-1:0]   table_entries_reg;

    // Table memory
    logic [RW-1:0]                   table_resistance [TABLE_DEPTH];
    logic [TW-1:0]                   table_temperature [TABLE_DEPTH];
    logic [RW-1:0]                   rd_res_reg;
    logic [TW-1:0]                   rd_temp_reg;
    logic [IW-1:0]                   rd_addr;
    logic                            wr_en;

    // Control and search state
    logic [3:0]                      state_reg, state_next;
    logic [RW-1:0]                   res_reg, res_next;
    logic                            err_reg, err_next;
    logic [NW-1:0]                   n_reg, n_next;
    logic [IW-1:0]                   lo_reg, lo_next;
    logic [NW-1:0]                   hi_reg, hi_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [TW-1:0]                   tlo_reg, tlo_next;
    logic [TW-1:0]                   temp_reg, temp_next;

    // Output register
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [TW-1:0]                   out_temp_reg, out_temp_next;
    logic [RW-1:0]                   out_res_reg, out_res_next;
    logic                            out_err_reg, out_err_next;

    logic                            accept;
    logic                            md_start;
    logic                            md_done;
    logic [RW-1:0]                   md_quotient;
    logic [CW-1:0]                   ent_ext;
    logic [NW-1:0]                   n_calc;
    logic                            probe_ge;
    logic [NW-1:0]                   lo_new;
    logic [NW-1:0]                   hi_new;
    logic [NW:0]                     mid_sum;
    logic [NW-1:0]                   idx_new;
    logic [IW-1:0]                   hi_clamp;

    // Unpack input item
    assign req_type            = s_tuser;
    assign entry_index         = s_tdata[ntc_lkp_pkg::IN_IDX_LSB +: ntc_lkp_pkg::IDX_W];
    assign entry_resistance    = s_tdata[ntc_lkp_pkg::IN_ERES_LSB +: RW];
    assign entry_temperature   = s_tdata[ntc_lkp_pkg::IN_ETEMP_LSB +: TW];
    assign source_mv           = s_tdata[ntc_lkp_pkg::IN_SRC_LSB +: MW];
    assign ntc_mv              = s_tdata[ntc_lkp_pkg::IN_NTC_LSB +: MW];
    assign measured_resistance = s_tdata[ntc_lkp_pkg::IN_MRES_LSB +: RW];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_resistor_reg <= RW'(10000);
            table_entries_reg <= ntc_lkp_pkg::ENT_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ntc_lkp_pkg::REG_LOAD:
                begin
                    load_resistor_reg <= cfg_wdata;
                end
                ntc_lkp_pkg::REG_ENTRIES:
                begin
                    table_entries_reg <= cfg_wdata[ntc_lkp_pkg::ENT_W-1:0];
                end
                default:
                begin
                    load_resistor_reg <= load_resistor_reg;
                end
            endcase
        end
    end

    // Entries in use, clamped to 1..TABLE_DEPTH
    assign ent_ext = CW'(table_entries_reg);
    always_comb
    begin
        if (ent_ext == '0)
        begin
            n_calc = NW'(1);
        end
        else if (ent_ext > CW'(TABLE_DEPTH))
        begin
            n_calc = NW'(TABLE_DEPTH);
        end
        else
        begin
            n_calc = NW'(ent_ext);
        end
    end

    // Table write from an accepted write item; drop indexes past the depth
    assign wr_en = accept && (req_type == ntc_lkp_pkg::REQ_WRITE)
                   && (EW'(entry_index) < EW'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_resistance[IW'(entry_index)]  <= entry_resistance;
            table_temperature[IW'(entry_index)] <= entry_temperature;
        end
        rd_res_reg  <= table_resistance[rd_addr];
        rd_temp_reg <= table_temperature[rd_addr];
    end

    // Upper bracket clamped to the last entry in use
    assign hi_clamp = (hi_reg == n_reg) ? IW'(n_reg - 1'b1) : IW'(hi_reg);

    // Read address per search phase
    always_comb
    begin
        case (state_reg)
            ST_SREAD: rd_addr = idx_reg;
            ST_FLO:   rd_addr = lo_reg;
            default:  rd_addr = hi_clamp;
        endcase
    end

    // Serial resistance from voltages
    assign md_start = accept && (req_type == ntc_lkp_pkg::REQ_VOLTAGE) && (ntc_mv < source_mv);

    ntc_lkp_muldiv u_muldiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .load     (load_resistor_reg),
        .ntc      (ntc_mv),
        .divisor  (source_mv - ntc_mv),
        .done     (md_done),
        .quotient (md_quotient)
    );

    // One bisection step
    assign probe_ge = rd_res_reg >= res_reg;
    assign lo_new   = probe_ge ? NW'(idx_reg) : NW'(lo_reg);
    assign hi_new   = probe_ge ? hi_reg : NW'(idx_reg);
    assign mid_sum  = (NW + 1)'(lo_new) + (NW + 1)'(hi_new);
    assign idx_new  = mid_sum[NW:1];

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        err_next      = err_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        idx_next      = idx_reg;
        tlo_next      = tlo_reg;
        temp_next     = temp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_temp_next = out_temp_reg;
        out_res_next  = out_res_reg;
        out_err_next  = out_err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        ntc_lkp_pkg::REQ_VOLTAGE:
                        begin
                            if (ntc_mv < source_mv)
                            begin
                                err_next   = 1'b0;
                                state_next = ST_ARITH;
                            end
                            else
                            begin
                                res_next   = ntc_lkp_pkg::RES_MAX;
                                err_next   = 1'b1;
                                state_next = ST_SINIT;
                            end
                        end
                        ntc_lkp_pkg::REQ_RES:
                        begin
                            res_next   = measured_resistance;
                            err_next   = 1'b0;
                            state_next = ST_SINIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ARITH:
            begin
                if (md_done)
                begin
                    res_next   = md_quotient;
                    state_next = ST_SINIT;
                end
            end
            ST_SINIT:
            begin
                n_next     = n_calc;
                lo_next    = '0;
                hi_next    = n_calc;
                idx_next   = IW'(n_calc >> 1);
                state_next = ST_SREAD;
            end
            ST_SREAD:
            begin
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                lo_next  = IW'(lo_new);
                hi_next  = hi_new;
                idx_next = IW'(idx_new);
                if ((idx_new == lo_new) || (idx_new == hi_new))
                begin
                    state_next = ST_FLO;
                end
                else
                begin
                    state_next = ST_SREAD;
                end
            end
            ST_FLO:
            begin
                state_next = ST_FHI;
            end
            ST_FHI:
            begin
                tlo_next   = rd_temp_reg;
                state_next = ST_FMAX;
            end
            ST_FMAX:
            begin
                temp_next  = ($signed(rd_temp_reg) > $signed(tlo_reg)) ? rd_temp_reg : tlo_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand over once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_temp_next = temp_reg;
                    out_res_next  = res_reg;
                    out_err_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Search and result payload
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        err_reg      <= err_next;
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        tlo_reg      <= tlo_next;
        temp_reg     <= temp_next;
        out_temp_reg <= out_temp_next;
        out_res_reg  <= out_res_next;
        out_err_reg  <= out_err_next;
    end

    // Pack result item
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_res_reg, out_temp_reg};
    assign m_tuser  = out_err_reg;

endmodule

// ===== hdl/ntc_lkp_muldiv.sv =====
`timescale 1ns / 1ps

// Bit-serial multiply then restoring divide: (ntc * load) / divisor,
// quotient saturated to 32 bits. One bit per cycle through a shared
// 48-bit shift word.
module ntc_lkp_muldiv
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ntc_lkp_pkg::RES_W-1:0]  load,
    input  logic [ntc_lkp_pkg::MV_W-1:0]   ntc,
    input  logic [ntc_lkp_pkg::MV_W-1:0]   divisor,
    output logic                           done,
    output logic [ntc_lkp_pkg::RES_W-1:0]  quotient
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_DONE = 2'd3;

    localparam int RW = ntc_lkp_pkg::RES_W;
    localparam int MW = ntc_lkp_pkg::MV_W;
    localparam int SW = ntc_lkp_pkg::STEP_W;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] hi_reg, hi_next;
    logic [MW-1:0] lo_reg, lo_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [MW-1:0] div_reg, div_next;

    logic [RW:0]   mul_sum;
    logic [MW:0]   trial;
    logic          fits;
    logic [MW:0]   trial_rem;

    // One multiply step: add load on the low multiplier bit, shift right
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, load} : '0);

    // One divide step: bring in the top bit, subtract when the divisor fits
    assign trial     = {rem_reg, hi_reg[RW-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign trial_rem = fits ? (trial - {1'b0, div_reg}) : trial;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    hi_next    = '0;
                    lo_next    = ntc;
                    rem_next   = '0;
                    div_next   = divisor;
                    cnt_next   = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                hi_next  = mul_sum[RW:1];
                lo_next  = {mul_sum[0], lo_reg[MW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(ntc_lkp_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next = trial_rem[MW-1:0];
                hi_next  = {hi_reg[RW-2:0], lo_reg[MW-1]};
                lo_next  = {lo_reg[MW-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(ntc_lkp_pkg::DIV_STEPS - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Data path word, remainder and divisor
    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // Saturate a quotient wider than 32 bits
    assign done     = (state_reg == MD_DONE);
    assign quotient = (hi_reg[RW-1:RW-MW] != '0) ? ntc_lkp_pkg::RES_MAX
                                                 : {hi_reg[RW-MW-1:0], lo_reg};

endmodule
